// File: rtl/vhos_pkg.sv
// Package for the value histogram and outlier statistics block.
// Holds widths, reset constants, error codes and the result kind codes.
// No dependencies.
package vhos_pkg;

  localparam int VAL_W      = 24;
  localparam int MAX_ITEMS_D = 1024;
  localparam int MAX_BINS_D  = 32;
  localparam int SUM_W      = 34;
  localparam int SQ_W       = 57;
  localparam int CNT_W      = 11;

  localparam logic [5:0] BIN_COUNT_RST = 6'd32;
  localparam logic [7:0] OUT_FACT_RST  = 8'd48;

  localparam logic [0:0] CFG_BIN_COUNT  = 1'b0;
  localparam logic [0:0] CFG_OUT_FACTOR = 1'b1;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_TOO_FEW  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  localparam logic KIND_BIN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic signed [VAL_W-1:0] VAL_MOST_POS = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = 24'sh800000;

  // Request record for the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } vhos_div_req_t;

endpackage

// File: rtl/value_histogram_and_outlier_stats.sv
// Top level of the value histogram and outlier statistics block.
// Depends on vhos_pkg, vhos_ram, vhos_div and vhos_sqrt.
//
//  channel | direction | handshake     | contents
//  in_     | input     | valid / stall | sample_value, sample_enabled, final_item
//  out_    | output    | valid / stall | one bin word or the summary word
//  cfg_    | input     | valid / ready | register index and data
//
// Loading takes one cycle per word. A final word starts the computation: mean and
// variance divisions, square root, a histogram pass that reads each stored value and
// runs a 64-step division and a count for each value in range, an outlier pass that
// reads and compares each stored value, then one bin word per cycle while out_stall
// is low and, once out_valid drops, the summary word (alone if under two values).
// Input stall stays high until the summary word is taken. Output words hold under
// out_stall. Reset clears all control state; the store needs no clearing.
module value_histogram_and_outlier_stats #(
  parameter int MAX_ITEMS = vhos_pkg::MAX_ITEMS_D,
  parameter int MAX_BINS  = vhos_pkg::MAX_BINS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_sample_value,
  input  logic        in_sample_enabled,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [4:0]  out_bin_index,
  output logic [10:0] out_bin_total,
  output logic [23:0] out_mean_value,
  output logic [23:0] out_sigma_value,
  output logic [23:0] out_minimum_value,
  output logic [24:0] out_maximum_value,
  output logic [10:0] out_outlier_total,
  output logic [10:0] out_largest_bin,
  output logic [10:0] out_smallest_bin,
  output logic [1:0]  out_error_code,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import vhos_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW = $clog2(MAX_ITEMS + 1);
  localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  typedef enum logic [3:0] {
    S_LOAD, S_MEAN, S_VAR, S_SQRT, S_BIN_RD, S_BIN_DIV, S_BIN_ADD,
    S_OUT_RD, S_OUT_CMP, S_EMIT, S_SUMMARY, S_CLEAR
  } state_t;

  state_t state_r;
  logic [5:0]  bin_count_r;
  logic [7:0]  outlier_factor_r;
  logic [NW-1:0] n_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0] sq_r;
  logic signed [VAL_W-1:0] min_r, max_r;
  logic ovf_r;
  logic [CNT_W-1:0] bins_r [MAX_BINS];
  logic [NW-1:0] idx_r;
  logic [BW:0]   bidx_r;
  logic signed [VAL_W+1:0] mean_r;
  logic [47:0]   am_sq_r;
  logic [31:0]   sigma_r;
  logic [CNT_W-1:0] outl_r, big_r, small_r;
  logic [6:0]    nb_r;
  logic signed [VAL_W+1:0] mx_r;
  logic signed [47:0] thr_r;
  logic          rd_wait_r, kick_r;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [VAL_W-1:0] ram_q;
  vhos_div_req_t div_req;
  logic div_busy, sq_start, sq_busy;
  logic [63:0] div_q;
  logic [31:0] sq_root;

  logic in_acc, out_acc;
  logic signed [VAL_W-1:0] sv;
  logic [6:0] nb_c;
  logic signed [VAL_W+1:0] mn_e, mx_c, v_e;
  logic [VAL_W:0] diff_b;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state_r != S_LOAD);
  assign cfg_ready = (state_r == S_LOAD);
  assign sv = in_sample_value;

  assign ram_we   = in_acc && in_sample_enabled && (n_r < NW'(MAX_ITEMS));
  assign ram_addr = ram_we ? n_r[AW-1:0] : idx_r[AW-1:0];

  vhos_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_sample_value), .rdata(ram_q)
  );

  vhos_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .busy(div_busy), .quot(div_q));

  vhos_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(div_q),
    .busy(sq_busy), .root(sq_root));

  // Bin count clamped into the legal range.
  always_comb begin
    nb_c = {1'b0, bin_count_r};
    if (nb_c == 7'd0) nb_c = 7'd1;
    if (nb_c > 7'(MAX_BINS)) nb_c = 7'(MAX_BINS);
  end

  assign mn_e = (VAL_W+2)'(min_r);
  assign mx_c = (VAL_W+2)'(max_r) < mn_e + 26'sd16 ? mn_e + 26'sd16 : (VAL_W+2)'(max_r);
  assign v_e  = (VAL_W+2)'($signed(ram_q));
  // Offset of an in-range value above the minimum; never negative.
  assign diff_b = (VAL_W+1)'(v_e - mn_e);

  // Divider requests come from the sequencer: mean, variance, then bin indices.
  logic [63:0] abs_sum, sub_v, num_v;
  always_comb begin
    abs_sum = sum_r[SUM_W-1] ? -64'(sum_r) : 64'(sum_r);
    sub_v   = 64'(am_sq_r) * 64'(n_r);
    num_v   = (64'(sq_r) >= sub_v) ? 64'(sq_r) - sub_v : 64'd0;
    div_req = '0;
    if (kick_r) begin
      div_req.start = 1'b1;
      case (state_r)
        S_MEAN: begin
          div_req.num = abs_sum;
          div_req.den = 64'(n_r);
        end
        S_VAR: begin
          div_req.num = num_v;
          div_req.den = 64'(n_r) - 64'd1;
        end
        S_BIN_DIV: begin
          div_req.num = {32'd0, 32'(diff_b * nb_r)};
          div_req.den = 64'(mx_r - mn_e);
        end
        default: div_req = '0;
      endcase
    end
  end
  assign sq_start = kick_r && (state_r == S_SQRT);

  logic [CNT_W-1:0] cur_bin;
  assign cur_bin = bins_r[bidx_r[BW-1:0]];

  // Sequencer with all run state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_LOAD;
      bin_count_r      <= BIN_COUNT_RST;
      outlier_factor_r <= OUT_FACT_RST;
      n_r   <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      min_r <= VAL_MOST_POS;
      max_r <= VAL_MOST_NEG;
      ovf_r <= 1'b0;
      for (int i = 0; i < MAX_BINS; i++) bins_r[i] <= '0;
      out_valid <= 1'b0;
      kick_r    <= 1'b0;
      rd_wait_r <= 1'b0;
    end else begin
      kick_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_index)
              CFG_BIN_COUNT:  bin_count_r      <= cfg_data[5:0];
              CFG_OUT_FACTOR: outlier_factor_r <= cfg_data;
              default: ;
            endcase
          end
          if (in_acc) begin
            if (in_sample_enabled) begin
              if (ram_we) begin
                n_r   <= n_r + NW'(1);
                sum_r <= sum_r + SUM_W'(sv);
                sq_r  <= sq_r + SQ_W'(48'(sv * sv));
                if (sv < min_r) min_r <= sv;
                if (sv > max_r) max_r <= sv;
              end else begin
                ovf_r <= 1'b1;
              end
            end
            if (in_final_item) begin
              state_r <= S_MEAN;
              kick_r  <= 1'b1;
            end
          end
        end
        // The quotient is the magnitude of the mean; its square feeds the variance.
        S_MEAN: begin
          if (n_r < NW'(2)) begin
            state_r <= S_SUMMARY;
          end else if (!kick_r && !div_busy) begin
            mean_r  <= sum_r[SUM_W-1] ? -(VAL_W+2)'(div_q) : (VAL_W+2)'(div_q);
            am_sq_r <= div_q[VAL_W-1:0] * div_q[VAL_W-1:0];
            state_r <= S_VAR;
            kick_r  <= 1'b1;
          end
        end
        S_VAR: begin
          if (!kick_r && !div_busy) begin
            state_r <= S_SQRT;
            kick_r  <= 1'b1;
          end
        end
        S_SQRT: begin
          if (!kick_r && !sq_busy) begin
            sigma_r <= sq_root;
            nb_r    <= nb_c;
            mx_r    <= mx_c;
            thr_r   <= 48'(mean_r) * 48'sd16 + $signed({16'd0, sq_root}) * $signed({40'd0, outlier_factor_r});
            idx_r   <= '0;
            outl_r  <= '0;
            rd_wait_r <= 1'b1;
            state_r <= S_BIN_RD;
          end
        end
        // Histogram pass: read a value, divide if in range, count.
        S_BIN_RD: begin
          if (idx_r == n_r) begin
            idx_r     <= '0;
            rd_wait_r <= 1'b1;
            state_r   <= S_OUT_RD;
          end else if (rd_wait_r) begin
            rd_wait_r <= 1'b0;
          end else if (v_e >= mn_e && v_e < mx_r) begin
            kick_r  <= 1'b1;
            state_r <= S_BIN_DIV;
          end else begin
            idx_r     <= idx_r + NW'(1);
            rd_wait_r <= 1'b1;
          end
        end
        S_BIN_DIV: begin
          if (!kick_r && !div_busy) state_r <= S_BIN_ADD;
        end
        S_BIN_ADD: begin
          if (div_q < 64'(nb_r)) bins_r[div_q[BW-1:0]] <= bins_r[div_q[BW-1:0]] + CNT_W'(1);
          idx_r     <= idx_r + NW'(1);
          rd_wait_r <= 1'b1;
          state_r   <= S_BIN_RD;
        end
        // Outlier pass over the store.
        S_OUT_RD: begin
          if (idx_r == n_r) begin
            bidx_r  <= '0;
            big_r   <= '0;
            small_r <= bins_r[0];
            state_r <= S_EMIT;
          end else if (rd_wait_r) begin
            rd_wait_r <= 1'b0;
          end else begin
            state_r <= S_OUT_CMP;
          end
        end
        S_OUT_CMP: begin
          if (48'(v_e) * 48'sd16 > thr_r) outl_r <= outl_r + CNT_W'(1);
          idx_r     <= idx_r + NW'(1);
          rd_wait_r <= 1'b1;
          state_r   <= S_OUT_RD;
        end
        S_EMIT: begin
          if (!out_valid || out_acc) begin
            if ((BW+1)'(bidx_r) == (BW+1)'(nb_r)) begin
              out_valid <= 1'b0;
              state_r   <= S_SUMMARY;
            end else begin
              out_valid         <= 1'b1;
              out_result_kind   <= KIND_BIN;
              out_bin_index     <= 5'(bidx_r);
              out_bin_total     <= cur_bin;
              out_mean_value    <= '0;
              out_sigma_value   <= '0;
              out_minimum_value <= '0;
              out_maximum_value <= '0;
              out_outlier_total <= '0;
              out_largest_bin   <= '0;
              out_smallest_bin  <= '0;
              out_error_code    <= ovf_r ? ERR_OVERFLOW : ERR_OK;
              out_last_result   <= 1'b0;
              if (cur_bin > big_r) big_r <= cur_bin;
              if (cur_bin < small_r) small_r <= cur_bin;
              bidx_r <= bidx_r + (BW+1)'(1);
            end
          end
        end
        S_SUMMARY: begin
          if (!out_valid || out_acc) begin
            out_valid       <= 1'b1;
            out_result_kind <= KIND_SUMMARY;
            out_bin_index   <= '0;
            out_bin_total   <= '0;
            out_last_result <= 1'b1;
            if (n_r < NW'(2)) begin
              out_mean_value    <= '0;
              out_sigma_value   <= '0;
              out_minimum_value <= '0;
              out_maximum_value <= '0;
              out_outlier_total <= '0;
              out_largest_bin   <= '0;
              out_smallest_bin  <= '0;
              out_error_code    <= ERR_TOO_FEW;
            end else begin
              out_mean_value    <= mean_r[VAL_W-1:0];
              out_sigma_value   <= sigma_r[VAL_W-1:0];
              out_minimum_value <= min_r;
              out_maximum_value <= mx_r[VAL_W:0];
              out_outlier_total <= outl_r;
              out_largest_bin   <= big_r;
              out_smallest_bin  <= small_r;
              out_error_code    <= ovf_r ? ERR_OVERFLOW : ERR_OK;
            end
            state_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            n_r   <= '0;
            sum_r <= '0;
            sq_r  <= '0;
            min_r <= VAL_MOST_POS;
            max_r <= VAL_MOST_NEG;
            ovf_r <= 1'b0;
            for (int i = 0; i < MAX_BINS; i++) bins_r[i] <= '0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // The store never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_ITEMS)) else $error("item count beyond store depth");
  // Input is only taken while loading.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> in_stall) else $error("input taken while busy");
  // The summary word always closes a run.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == out_result_kind)) else $error("last flag mismatch");
  // Run state is clear after the summary word goes.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && out_acc) |=> (n_r == '0)) else $error("run not cleared");

endmodule

// File: rtl/vhos_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module vhos_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle at one address; a write also reads out the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/vhos_div.sv
// Shared restoring divider, one quotient bit a cycle, 64-bit unsigned.
// Depends on vhos_pkg.
module vhos_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vhos_pkg::vhos_div_req_t req,
  output logic                   busy,
  output logic [63:0]            quot
);
  import vhos_pkg::*;

  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [64:0] trial;

  // Shift one numerator bit into the remainder and try a subtract.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial   = '0;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      trial = {rem_r, quo_r[63]} - {1'b0, den_r};
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy = (cnt_r != 7'd0) || req.start;
  assign quot = quo_r;

endmodule

// File: rtl/vhos_sqrt.sv
// Bit-pair floor square root of a 64-bit value, one step a cycle.
// No dependencies.
module vhos_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;

  // Classic digit-by-digit method over 32 steps.
  always_comb begin
    x_nxt   = x_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    if (start) begin
      x_nxt   = radicand;
      res_nxt = '0;
      bit_nxt = 64'h4000_0000_0000_0000;
    end else if (bit_r != 64'd0) begin
      if (x_r >= res_r + bit_r) begin
        x_nxt   = x_r - (res_r + bit_r);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else begin
      bit_r <= bit_nxt;
    end
    x_r   <= x_nxt;
    res_r <= res_nxt;
  end

  assign busy = (bit_r != 64'd0) || start;
  assign root = res_r[31:0];

endmodule

// File: tb/tb_value_histogram_and_outlier_stats.sv
// Testbench for the value histogram and outlier statistics block.
// Drives sample words and register writes, predicts every result word with an
// independent model held in a scoreboard class. Depends on vhos_pkg and the RTL.
`timescale 1ns / 100ps

module tb_value_histogram_and_outlier_stats;
  import vhos_pkg::*;

  // Expected contents of one result word.
  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    logic [10:0] total;
    logic [23:0] mean;
    logic [23:0] sigma;
    logic [23:0] minv;
    logic [24:0] maxv;
    logic [10:0] outl;
    logic [10:0] big;
    logic [10:0] little;
    logic [1:0]  err;
    logic        last;
  } stats_word_t;

  // Scoreboard: keeps its own copy of the run state and predicts result words.
  class stats_scoreboard;
    logic [5:0]  bins_reg;
    logic [7:0]  factor_reg;
    longint      held[MAX_ITEMS_D];
    int          held_n;
    longint      sum;
    longint      sqsum;
    longint      vmin;
    longint      vmax;
    bit          dropped;
    stats_word_t pending[$];
    int          errors;
    int          words_seen;
    int          sets_done;

    function new();
      bins_reg = BIN_COUNT_RST;
      factor_reg = OUT_FACT_RST;
      errors = 0;
      words_seen = 0;
      sets_done = 0;
      clear_set();
    endfunction

    function void clear_set();
      held_n = 0;
      sum = 0;
      sqsum = 0;
      vmin = 8388607;
      vmax = -8388608;
      dropped = 0;
    endfunction

    function longint isqrt(longint x);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 62;
      while (b > x) b = b >>> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    // Notes one accepted sample word and predicts what it finishes.
    function void note_sample(logic [23:0] raw, logic en, logic fin);
      longint      v;
      longint      mn;
      longint      mx;
      longint      rng;
      longint      mean;
      longint      am;
      longint      num;
      longint      sigma;
      longint      thr;
      int          nb;
      int          cnt[MAX_BINS_D];
      int          big;
      int          little;
      int          outl;
      logic [1:0]  err;
      stats_word_t w;
      v = longint'($signed(raw));
      if (en) begin
        if (held_n >= MAX_ITEMS_D) begin
          dropped = 1;
        end else begin
          held[held_n] = v;
          held_n++;
          sum += v;
          sqsum += v * v;
          if (v < vmin) vmin = v;
          if (v > vmax) vmax = v;
        end
      end
      if (!fin) return;
      sets_done++;
      w = '0;
      if (held_n < 2) begin
        w.kind = KIND_SUMMARY;
        w.err = ERR_TOO_FEW;
        w.last = 1'b1;
        pending.insert(pending.size(), w);
        clear_set();
        return;
      end
      err = dropped ? ERR_OVERFLOW : ERR_OK;
      nb = (bins_reg == 0) ? 1 : (bins_reg > MAX_BINS_D ? MAX_BINS_D : bins_reg);
      mn = vmin;
      mx = (vmax < vmin + 16) ? vmin + 16 : vmax;
      rng = mx - mn;
      for (int i = 0; i < MAX_BINS_D; i++) cnt[i] = 0;
      for (int i = 0; i < held_n; i++)
        if (held[i] >= mn && held[i] < mx) cnt[((held[i] - mn) * nb) / rng]++;
      mean = sum / held_n;
      am = mean < 0 ? -mean : mean;
      num = (sqsum >= held_n * am * am) ? sqsum - held_n * am * am : 0;
      sigma = isqrt(num / (held_n - 1));
      thr = mean * 16 + sigma * factor_reg;
      outl = 0;
      for (int i = 0; i < held_n; i++) if (held[i] * 16 > thr) outl++;
      big = 0;
      little = cnt[0];
      for (int i = 0; i < nb; i++) begin
        if (cnt[i] > big) big = cnt[i];
        if (cnt[i] < little) little = cnt[i];
        w = '0;
        w.kind = KIND_BIN;
        w.idx = 5'(i);
        w.total = 11'(cnt[i]);
        w.err = err;
        pending.insert(pending.size(), w);
      end
      w = '0;
      w.kind = KIND_SUMMARY;
      w.mean = 24'(mean);
      w.sigma = 24'(sigma);
      w.minv = 24'(mn);
      w.maxv = 25'(mx);
      w.outl = 11'(outl);
      w.big = 11'(big);
      w.little = 11'(little);
      w.err = err;
      w.last = 1'b1;
      pending.insert(pending.size(), w);
      clear_set();
    endfunction

    // Compares one received word with the oldest expectation.
    function void check_word(stats_word_t got);
      stats_word_t exp_w;
      words_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result word %p", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.kind !== exp_w.kind) fail("result_kind", exp_w.kind, got.kind);
      if (got.idx !== exp_w.idx) fail("bin_index", exp_w.idx, got.idx);
      if (got.total !== exp_w.total) fail("bin_total", exp_w.total, got.total);
      if (got.mean !== exp_w.mean) fail("mean_value", exp_w.mean, got.mean);
      if (got.sigma !== exp_w.sigma) fail("sigma_value", exp_w.sigma, got.sigma);
      if (got.minv !== exp_w.minv) fail("minimum_value", exp_w.minv, got.minv);
      if (got.maxv !== exp_w.maxv) fail("maximum_value", exp_w.maxv, got.maxv);
      if (got.outl !== exp_w.outl) fail("outlier_total", exp_w.outl, got.outl);
      if (got.big !== exp_w.big) fail("largest_bin", exp_w.big, got.big);
      if (got.little !== exp_w.little) fail("smallest_bin", exp_w.little, got.little);
      if (got.err !== exp_w.err) fail("error_code", exp_w.err, got.err);
      if (got.last !== exp_w.last) fail("last_result", exp_w.last, got.last);
    endfunction

    function void fail(string field, logic [31:0] e, logic [31:0] a);
      $error("%s: expected %0h, got %0h", field, e, a);
      errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] in_sample_value;
  logic        in_sample_enabled;
  logic        in_final_item;
  logic        out_valid;
  logic        out_stall;
  stats_word_t got_w;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;

  stats_scoreboard sb;
  bit  quiet;
  int  idle_cycles;

  value_histogram_and_outlier_stats dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_value(in_sample_value), .in_sample_enabled(in_sample_enabled),
    .in_final_item(in_final_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(got_w.kind), .out_bin_index(got_w.idx),
    .out_bin_total(got_w.total), .out_mean_value(got_w.mean),
    .out_sigma_value(got_w.sigma), .out_minimum_value(got_w.minv),
    .out_maximum_value(got_w.maxv), .out_outlier_total(got_w.outl),
    .out_largest_bin(got_w.big), .out_smallest_bin(got_w.little),
    .out_error_code(got_w.err), .out_last_result(got_w.last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall, except during quiet stretches; checks words.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(got_w);
    out_stall <= !quiet && ($urandom_range(99) < 10);
  end

  // Watchdog: counts cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sends one sample word, with an occasional idle gap beforehand. Valid stays
  // high after the handshake so that words can follow back to back.
  task automatic send_sample(logic [23:0] v, logic en, logic fin);
    cfg_valid <= 0;
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_sample_value <= v;
    in_sample_enabled <= en;
    in_final_item <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_sample(v, en, fin);
  endtask

  // Drops the input, waits for all expected words, then lets the block settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write; valid is dropped by the next sample word.
  task automatic write_reg(logic [0:0] idx, logic [7:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BIN_COUNT) sb.bins_reg = data[5:0];
    else sb.factor_reg = data;
  endtask

  // One set of random values; mostly narrow spreads so bins fill unevenly.
  task automatic random_set(int n);
    logic [23:0] base;
    logic [23:0] v;
    int          span;
    base = 24'($urandom);
    span = 1 << $urandom_range(23);
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(9) == 0) ? 24'($urandom) : 24'(base + 24'($urandom_range(span)));
      send_sample(v, $urandom_range(9) != 0, i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    quiet = 0;
    idle_cycles = 0;
    rst_n = 0;
    in_valid = 0;
    in_sample_value = '0;
    in_sample_enabled = 0;
    in_final_item = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CFG_BIN_COUNT;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes at reset settings, lone final word, skipped final.
    send_sample(24'h7FFFFF, 1, 0);
    send_sample(24'h800000, 1, 0);
    send_sample(24'h000000, 1, 0);
    send_sample(24'h123456, 0, 1);
    send_sample(24'h000010, 1, 1);
    send_sample(24'h000005, 0, 1);
    drain();

    // Narrow range raised to sixteen units, single bin, zero factor.
    write_reg(CFG_BIN_COUNT, 8'd1);
    write_reg(CFG_OUT_FACTOR, 8'd0);
    send_sample(24'hFFFFF0, 1, 0);
    send_sample(24'hFFFFF0, 1, 0);
    send_sample(24'hFFFFF8, 1, 1);
    drain();

    // Zero and over-range bin counts, largest factor.
    write_reg(CFG_BIN_COUNT, 8'd0);
    write_reg(CFG_OUT_FACTOR, 8'd255);
    send_sample(24'h000100, 1, 0);
    send_sample(24'h000200, 1, 1);
    drain();
    write_reg(CFG_BIN_COUNT, 8'd63);
    send_sample(24'h800000, 1, 0);
    send_sample(24'h7FFFFF, 1, 0);
    send_sample(24'h400000, 1, 1);
    drain();

    // Random sets under several register settings, with a quiet stretch midway.
    for (int s = 0; s < 25; s++) begin
      quiet = (s >= 10) && (s < 15);
      write_reg(CFG_BIN_COUNT, 8'($urandom_range(63)));
      write_reg(CFG_OUT_FACTOR, 8'($urandom_range(255)));
      random_set($urandom_range(1, 18));
      drain();
    end
    quiet = 0;

    $display("Covered %0d sets and %0d result words across bin and factor settings.",
             sb.sets_done, sb.words_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
